### rtl/ral_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ral_pkg
// Shared types, constants, CRC-16 byte step and the microcode ROM of the
// register-access link sequencer.
// ----------------------------------------------------------------------------
package ral_pkg;

  localparam int RX_DEPTH = 16;
  localparam int RX_AW    = $clog2(RX_DEPTH);
  localparam int RX_CW    = $clog2(RX_DEPTH + 1);
  localparam int REPLY_LEN = 11;
  localparam int STEP_W   = 6;

  localparam logic [7:0] SYNC0      = 8'hAA;
  localparam logic [7:0] SYNC1      = 8'h55;
  localparam logic [7:0] OP_WRITE   = 8'h82;
  localparam logic [7:0] OP_READ    = 8'h83;
  localparam logic [7:0] LEN_WRITE  = 8'(5 + 2);
  localparam logic [7:0] LEN_READ   = 8'(5 + 2 - 1);
  localparam logic [7:0] READ_WORDS = 8'h01;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [2:0] MISS_LIMIT_RST = 3'd5;

  localparam logic [STEP_W-1:0] ENTRY_WRITE = 6'd0;
  localparam logic [STEP_W-1:0] ENTRY_READ  = 6'd10;
  localparam logic [STEP_W-1:0] ENTRY_POLL  = 6'd20;
  localparam logic [STEP_W-1:0] STEP_MISS   = 6'd33;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_RXB   = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_WAIT    = 3'd0,
    ST_OK      = 3'd1,
    ST_TIMEOUT = 3'd2,
    ST_HDR     = 3'd3,
    ST_CRC     = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    SEL_SYNC0, SEL_SYNC1, SEL_LEN_WR, SEL_LEN_RD, SEL_OP_WR, SEL_OP_RD,
    SEL_ADDR_H, SEL_ADDR_L, SEL_DATA_H, SEL_DATA_L, SEL_ONE,
    SEL_CRC_L, SEL_CRC_H, SEL_RXD, SEL_ZERO
  } byte_sel_t;

  typedef enum logic [3:0] {
    CHK_NONE, CHK_SYNC0, CHK_SYNC1, CHK_ADDR_H, CHK_ADDR_L,
    CHK_CRC_L, CHK_CRC_H, CHK_DATA_H, CHK_DATA_L
  } chk_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_BR_MISS, OP_SET_WAIT, OP_POLL_DONE, OP_MISS
  } seq_op_t;

  typedef struct packed {
    logic             emit;
    logic             kind;
    logic             last;
    logic             fin;
    byte_sel_t        sel;
    logic             crc_en;
    chk_t             chk;
    logic [RX_AW-1:0] rd_addr;
    seq_op_t          op;
  } ctrl_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic ctrl_t mk(input logic emit, input logic kind, input logic last,
                               input logic fin, input byte_sel_t sel, input logic crc_en,
                               input chk_t chk, input int rd, input seq_op_t op);
    ctrl_t c;
    c.emit    = emit;
    c.kind    = kind;
    c.last    = last;
    c.fin     = fin;
    c.sel     = sel;
    c.crc_en  = crc_en;
    c.chk     = chk;
    c.rd_addr = RX_AW'(rd);
    c.op      = op;
    return c;
  endfunction

  function automatic ctrl_t ctrl_rom(input logic [STEP_W-1:0] idx);
    ctrl_t c;
    case (idx)
      // write frame
      6'd0:  c = mk(1'b1, 1'b0, 1'b0, 1'b0, SEL_SYNC0,  1'b0, CHK_NONE, 0, OP_NONE);
      6'd1:  c = mk(1'b1, 1'b0, 1'b0, 1'b0, SEL_SYNC1,  1'b0, CHK_NONE, 0, OP_NONE);
      6'd2:  c = mk(1'b1, 1'b0, 1'b0, 1'b0, SEL_LEN_WR, 1'b0, CHK_NONE, 0, OP_NONE);
      6'd3:  c = mk(1'b1, 1'b0, 1'b0, 1'b0, SEL_OP_WR,  1'b1, CHK_NONE, 0, OP_NONE);
      6'd4:  c = mk(1'b1, 1'b0, 1'b0, 1'b0, SEL_ADDR_H, 1'b1, CHK_NONE, 0, OP_NONE);
      6'd5:  c = mk(1'b1, 1'b0, 1'b0, 1'b0, SEL_ADDR_L, 1'b1, CHK_NONE, 0, OP_NONE);
      6'd6:  c = mk(1'b1, 1'b0, 1'b0, 1'b0, SEL_DATA_H, 1'b1, CHK_NONE, 0, OP_NONE);
      6'd7:  c = mk(1'b1, 1'b0, 1'b0, 1'b0, SEL_DATA_L, 1'b1, CHK_NONE, 0, OP_NONE);
      6'd8:  c = mk(1'b1, 1'b0, 1'b0, 1'b0, SEL_CRC_L,  1'b0, CHK_NONE, 0, OP_NONE);
      6'd9:  c = mk(1'b1, 1'b0, 1'b1, 1'b1, SEL_CRC_H,  1'b0, CHK_NONE, 0, OP_NONE);
      // read request
      6'd10: c = mk(1'b1, 1'b0, 1'b0, 1'b0, SEL_SYNC0,  1'b0, CHK_NONE, 0, OP_NONE);
      6'd11: c = mk(1'b1, 1'b0, 1'b0, 1'b0, SEL_SYNC1,  1'b0, CHK_NONE, 0, OP_NONE);
      6'd12: c = mk(1'b1, 1'b0, 1'b0, 1'b0, SEL_LEN_RD, 1'b0, CHK_NONE, 0, OP_NONE);
      6'd13: c = mk(1'b1, 1'b0, 1'b0, 1'b0, SEL_OP_RD,  1'b1, CHK_NONE, 0, OP_NONE);
      6'd14: c = mk(1'b1, 1'b0, 1'b0, 1'b0, SEL_ADDR_H, 1'b1, CHK_NONE, 0, OP_NONE);
      6'd15: c = mk(1'b1, 1'b0, 1'b0, 1'b0, SEL_ADDR_L, 1'b1, CHK_NONE, 0, OP_NONE);
      6'd16: c = mk(1'b1, 1'b0, 1'b0, 1'b0, SEL_ONE,    1'b1, CHK_NONE, 0, OP_NONE);
      6'd17: c = mk(1'b1, 1'b0, 1'b0, 1'b0, SEL_CRC_L,  1'b0, CHK_NONE, 0, OP_NONE);
      6'd18: c = mk(1'b1, 1'b0, 1'b0, 1'b0, SEL_CRC_H,  1'b0, CHK_NONE, 0, OP_NONE);
      6'd19: c = mk(1'b1, 1'b1, 1'b1, 1'b1, SEL_ZERO,   1'b0, CHK_NONE, 0, OP_SET_WAIT);
      // poll: read buffer one byte per step, data lags address by one step
      6'd20: c = mk(1'b0, 1'b0, 1'b0, 1'b0, SEL_RXD, 1'b0, CHK_NONE,   0,  OP_BR_MISS);
      6'd21: c = mk(1'b0, 1'b0, 1'b0, 1'b0, SEL_RXD, 1'b0, CHK_SYNC0,  1,  OP_NONE);
      6'd22: c = mk(1'b0, 1'b0, 1'b0, 1'b0, SEL_RXD, 1'b0, CHK_SYNC1,  2,  OP_NONE);
      6'd23: c = mk(1'b0, 1'b0, 1'b0, 1'b0, SEL_RXD, 1'b0, CHK_NONE,   3,  OP_NONE);
      6'd24: c = mk(1'b0, 1'b0, 1'b0, 1'b0, SEL_RXD, 1'b1, CHK_NONE,   4,  OP_NONE);
      6'd25: c = mk(1'b0, 1'b0, 1'b0, 1'b0, SEL_RXD, 1'b1, CHK_ADDR_H, 5,  OP_NONE);
      6'd26: c = mk(1'b0, 1'b0, 1'b0, 1'b0, SEL_RXD, 1'b1, CHK_ADDR_L, 6,  OP_NONE);
      6'd27: c = mk(1'b0, 1'b0, 1'b0, 1'b0, SEL_RXD, 1'b1, CHK_NONE,   7,  OP_NONE);
      6'd28: c = mk(1'b0, 1'b0, 1'b0, 1'b0, SEL_RXD, 1'b1, CHK_DATA_H, 8,  OP_NONE);
      6'd29: c = mk(1'b0, 1'b0, 1'b0, 1'b0, SEL_RXD, 1'b1, CHK_DATA_L, 9,  OP_NONE);
      6'd30: c = mk(1'b0, 1'b0, 1'b0, 1'b0, SEL_RXD, 1'b0, CHK_CRC_L,  10, OP_NONE);
      6'd31: c = mk(1'b0, 1'b0, 1'b0, 1'b0, SEL_RXD, 1'b0, CHK_CRC_H,  0,  OP_NONE);
      6'd32: c = mk(1'b1, 1'b1, 1'b1, 1'b1, SEL_ZERO, 1'b0, CHK_NONE,  0,  OP_POLL_DONE);
      6'd33: c = mk(1'b1, 1'b1, 1'b1, 1'b1, SEL_ZERO, 1'b0, CHK_NONE,  0,  OP_MISS);
      default: c = mk(1'b0, 1'b0, 1'b0, 1'b1, SEL_ZERO, 1'b0, CHK_NONE, 0, OP_NONE);
    endcase
    return c;
  endfunction

endpackage

### rtl/crc16_register_access_link.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc16_register_access_link
// Master side of a framed serial register-access link with CRC-16/MODBUS.
// A microcode ROM sequences frame transmission and reply checking.
//
//   channel  direction  handshake             beat payload
//   in_      input      in_valid / in_stall   cmd, addr, wdata, rx_byte
//   out_     output     out_valid / out_stall kind, tx_byte, last, status, read_data
//   cfg_     input      cfg_we                miss_limit (cfg_wdata)
//
// One microcode step per clock; an emitting step waits while the output beat
// is held. Write access: 10 steps; read request: 10 steps; poll: 2 steps on a
// miss, 13 on a full reply (buffer read one byte per step). Received byte: no
// busy time. in_stall is high while a program runs. Reset is
// synchronous; the receive buffer needs no clearing.
// ----------------------------------------------------------------------------
module crc16_register_access_link (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_addr,
  input  logic [15:0] in_wdata,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_tx_byte,
  output logic        out_last,
  output logic [2:0]  out_status,
  output logic [15:0] out_read_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata
);

  logic                          busy_r, busy_nxt;
  logic [ral_pkg::STEP_W-1:0]    step_r, step_nxt;
  logic [15:0]                   addr_r, addr_nxt;
  logic [15:0]                   wdata_r, wdata_nxt;
  logic [15:0]                   crc_r, crc_nxt;
  logic                          hdr_err_r, hdr_err_nxt;
  logic                          crc_err_r, crc_err_nxt;
  logic [15:0]                   data_r, data_nxt;
  logic                          await_r, await_nxt;
  logic [2:0]                    miss_cnt_r, miss_cnt_nxt;
  logic [ral_pkg::RX_CW-1:0]     rx_cnt_r, rx_cnt_nxt;
  logic [2:0]                    miss_limit_r, miss_limit_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_kind_r, out_kind_nxt;
  logic [7:0]                    out_tx_r, out_tx_nxt;
  logic                          out_last_r, out_last_nxt;
  logic [2:0]                    out_status_r, out_status_nxt;
  logic [15:0]                   out_data_r, out_data_nxt;

  ral_pkg::ctrl_t                cw;
  ral_pkg::status_t              rpt_status;
  logic [15:0]                   rpt_data;
  logic                          in_acc;
  logic                          go;
  logic                          miss;
  logic                          timeout;
  logic                          ram_we;
  logic [7:0]                    rd_byte;
  logic [7:0]                    cur_byte;

  assign cw       = ral_pkg::ctrl_rom(step_r);
  assign in_stall = busy_r;
  assign in_acc   = in_valid & ~busy_r;
  assign go       = busy_r & (~cw.emit | ~out_valid_r | ~out_stall);
  assign miss     = rx_cnt_r != ral_pkg::RX_CW'(ral_pkg::REPLY_LEN);
  assign timeout  = miss_cnt_r >= miss_limit_r;

  ral_ram #(
    .WIDTH (8),
    .DEPTH (ral_pkg::RX_DEPTH)
  ) u_rx_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (rx_cnt_r[ral_pkg::RX_AW-1:0]),
    .wdata (in_rx_byte),
    .raddr (cw.rd_addr),
    .rdata (rd_byte)
  );

  always_comb begin
    case (cw.sel)
      ral_pkg::SEL_SYNC0:  cur_byte = ral_pkg::SYNC0;
      ral_pkg::SEL_SYNC1:  cur_byte = ral_pkg::SYNC1;
      ral_pkg::SEL_LEN_WR: cur_byte = ral_pkg::LEN_WRITE;
      ral_pkg::SEL_LEN_RD: cur_byte = ral_pkg::LEN_READ;
      ral_pkg::SEL_OP_WR:  cur_byte = ral_pkg::OP_WRITE;
      ral_pkg::SEL_OP_RD:  cur_byte = ral_pkg::OP_READ;
      ral_pkg::SEL_ADDR_H: cur_byte = addr_r[15:8];
      ral_pkg::SEL_ADDR_L: cur_byte = addr_r[7:0];
      ral_pkg::SEL_DATA_H: cur_byte = wdata_r[15:8];
      ral_pkg::SEL_DATA_L: cur_byte = wdata_r[7:0];
      ral_pkg::SEL_ONE:    cur_byte = ral_pkg::READ_WORDS;
      ral_pkg::SEL_CRC_L:  cur_byte = crc_r[7:0];
      ral_pkg::SEL_CRC_H:  cur_byte = crc_r[15:8];
      ral_pkg::SEL_RXD:    cur_byte = rd_byte;
      default:             cur_byte = 8'h00;
    endcase
  end

  always_comb begin
    rpt_data = 16'h0000;
    case (cw.op)
      ral_pkg::OP_MISS: begin
        rpt_status = timeout ? ral_pkg::ST_TIMEOUT : ral_pkg::ST_WAIT;
      end
      ral_pkg::OP_POLL_DONE: begin
        if (hdr_err_r) begin
          rpt_status = ral_pkg::ST_HDR;
        end else begin
          rpt_status = crc_err_r ? ral_pkg::ST_CRC : ral_pkg::ST_OK;
          rpt_data   = data_r;
        end
      end
      default: rpt_status = ral_pkg::ST_WAIT;
    endcase
  end

  always_comb begin
    busy_nxt       = busy_r;
    step_nxt       = step_r;
    addr_nxt       = addr_r;
    wdata_nxt      = wdata_r;
    crc_nxt        = crc_r;
    hdr_err_nxt    = hdr_err_r;
    crc_err_nxt    = crc_err_r;
    data_nxt       = data_r;
    await_nxt      = await_r;
    miss_cnt_nxt   = miss_cnt_r;
    rx_cnt_nxt     = rx_cnt_r;
    miss_limit_nxt = cfg_we ? cfg_wdata : miss_limit_r;
    out_valid_nxt  = out_valid_r & out_stall;
    out_kind_nxt   = out_kind_r;
    out_tx_nxt     = out_tx_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;

    if (in_acc) begin
      addr_nxt    = in_addr;
      wdata_nxt   = in_wdata;
      crc_nxt     = ral_pkg::CRC_INIT;
      hdr_err_nxt = 1'b0;
      crc_err_nxt = 1'b0;
      case (in_cmd)
        ral_pkg::CMD_WRITE: begin
          busy_nxt = 1'b1;
          step_nxt = ral_pkg::ENTRY_WRITE;
        end
        ral_pkg::CMD_READ: begin
          busy_nxt = 1'b1;
          step_nxt = await_r ? ral_pkg::ENTRY_POLL : ral_pkg::ENTRY_READ;
        end
        ral_pkg::CMD_RXB: begin
          if (rx_cnt_r < ral_pkg::RX_CW'(ral_pkg::RX_DEPTH)) begin
            ram_we     = 1'b1;
            rx_cnt_nxt = rx_cnt_r + 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (go) begin
      busy_nxt = ~cw.fin;
      step_nxt = step_r + 1'b1;
      if (cw.crc_en) begin
        crc_nxt = ral_pkg::crc16_byte(crc_r, cur_byte);
      end
      case (cw.chk)
        ral_pkg::CHK_SYNC0:  if (rd_byte != ral_pkg::SYNC0) hdr_err_nxt = 1'b1;
        ral_pkg::CHK_SYNC1:  if (rd_byte != ral_pkg::SYNC1) hdr_err_nxt = 1'b1;
        ral_pkg::CHK_ADDR_H: if (rd_byte != addr_r[15:8]) hdr_err_nxt = 1'b1;
        ral_pkg::CHK_ADDR_L: if (rd_byte != addr_r[7:0]) hdr_err_nxt = 1'b1;
        ral_pkg::CHK_CRC_L:  if (rd_byte != crc_r[7:0]) crc_err_nxt = 1'b1;
        ral_pkg::CHK_CRC_H:  if (rd_byte != crc_r[15:8]) crc_err_nxt = 1'b1;
        ral_pkg::CHK_DATA_H: data_nxt[15:8] = rd_byte;
        ral_pkg::CHK_DATA_L: data_nxt[7:0] = rd_byte;
        default: ;
      endcase
      case (cw.op)
        ral_pkg::OP_BR_MISS: begin
          if (miss) step_nxt = ral_pkg::STEP_MISS;
        end
        ral_pkg::OP_SET_WAIT: await_nxt = 1'b1;
        ral_pkg::OP_POLL_DONE: begin
          miss_cnt_nxt = 3'd0;
          await_nxt    = 1'b0;
          rx_cnt_nxt   = '0;
        end
        ral_pkg::OP_MISS: begin
          if (timeout) begin
            miss_cnt_nxt = 3'd0;
            await_nxt    = 1'b0;
            rx_cnt_nxt   = '0;
          end else begin
            miss_cnt_nxt = miss_cnt_r + 3'd1;
          end
        end
        default: ;
      endcase
      if (cw.emit) begin
        out_valid_nxt  = 1'b1;
        out_kind_nxt   = cw.kind;
        out_tx_nxt     = cw.kind ? 8'h00 : cur_byte;
        out_last_nxt   = cw.last;
        out_status_nxt = rpt_status;
        out_data_nxt   = rpt_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      step_r       <= '0;
      await_r      <= 1'b0;
      miss_cnt_r   <= 3'd0;
      rx_cnt_r     <= '0;
      miss_limit_r <= ral_pkg::MISS_LIMIT_RST;
      out_valid_r  <= 1'b0;
    end else begin
      busy_r       <= busy_nxt;
      step_r       <= step_nxt;
      await_r      <= await_nxt;
      miss_cnt_r   <= miss_cnt_nxt;
      rx_cnt_r     <= rx_cnt_nxt;
      miss_limit_r <= miss_limit_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r       <= addr_nxt;
    wdata_r      <= wdata_nxt;
    crc_r        <= crc_nxt;
    hdr_err_r    <= hdr_err_nxt;
    crc_err_r    <= crc_err_nxt;
    data_r       <= data_nxt;
    out_kind_r   <= out_kind_nxt;
    out_tx_r     <= out_tx_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_tx_byte   = out_tx_r;
  assign out_last      = out_last_r;
  assign out_status    = out_status_r;
  assign out_read_data = out_data_r;

endmodule

### rtl/ral_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ral_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ral_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/ral_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ral_checker
// Port-level checks of the register-access link, bound to the top level.
// ----------------------------------------------------------------------------
module ral_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_cmd,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_kind,
  input logic [7:0]  out_tx_byte,
  input logic        out_last,
  input logic [2:0]  out_status,
  input logic [15:0] out_read_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tx_byte) && $stable(out_status)
      && $stable(out_kind) && $stable(out_read_data) && $stable(out_last))
    else $error("held output beat changed");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("link not idle after reset");

  a_access_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_cmd == ral_pkg::CMD_WRITE || in_cmd == ral_pkg::CMD_READ)
      |=> in_stall)
    else $error("access accepted without starting a program");

  a_rxb_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_cmd == ral_pkg::CMD_RXB && !out_valid |=> !out_valid)
    else $error("received byte produced a beat");

  a_beat_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind ? (out_tx_byte == 8'h00 && out_last)
                            : (out_status == ral_pkg::ST_WAIT && out_read_data == 16'h0000)))
    else $error("malformed output beat");

endmodule

bind crc16_register_access_link ral_checker u_ral_checker (.*);
